// ===== sv/gptad_pkg.sv =====
// Shared types and constants of the grid path turn angle decimator.
// Depends on nothing; every other file of the block imports it.
package gptad_pkg;

	localparam int unsigned CELL_BITS_DEF = 12;
	localparam int unsigned RES_W = 20;
	localparam int unsigned TAN_W = 16;
	localparam int unsigned WORLD_W = 32;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned CFG_ADDR_W = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_RESOLUTION = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_TAN_THRESHOLD = CFG_ADDR_W'(3);

	localparam logic [RES_W-1:0] RESOLUTION_RST = RES_W'(3277);
	localparam logic [TAN_W-1:0] TAN_THRESHOLD_RST = TAN_W'(21294);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // take the incoming cell word
		logic hold_first; // held cell <= current cell
		logic shift;      // older <= held, held <= current
		logic turn_step;  // advance the turn test pipeline
		logic wmul;       // multiply the selected cell by the resolution
		logic sel_held;   // selected cell is the held one, else the current one
		logic load_out;   // load the output register
		logic last;       // last_waypoint flag for the loaded word
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_end;  // captured cell closes the path
		logic keep;     // turn test result for the held cell
		logic out_free; // output register can take a word this cycle
	} dp_sts_t;

endpackage

// ===== sv/gptad_if.sv =====
// Stream and configuration interfaces of the grid path turn angle decimator.
// Depends on gptad_pkg for default widths.
interface gptad_cell_if import gptad_pkg::*; #(
	parameter int unsigned CELL_BITS = CELL_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [CELL_BITS-1:0] grid_row;
	logic [CELL_BITS-1:0] grid_col;
	logic                 path_end;

	modport source (output valid, output grid_row, output grid_col, output path_end,
		input ready);
	modport sink (input valid, input grid_row, input grid_col, input path_end,
		output ready);
endinterface

interface gptad_wpt_if import gptad_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [WORLD_W-1:0] world_x;
	logic signed [WORLD_W-1:0] world_y;
	logic                      last_waypoint;

	modport source (output valid, output world_x, output world_y, output last_waypoint,
		input ready);
	modport sink (input valid, input world_x, input world_y, input last_waypoint,
		output ready);
endinterface

interface gptad_cfg_if import gptad_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== sv/gptad_dp.sv =====
// Datapath of the grid path turn angle decimator: registers, cell history,
// turn test pipeline, world mapping and output register. Depends on gptad_pkg.
module gptad_dp import gptad_pkg::*; #(
	parameter int unsigned CELL_BITS = CELL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [CELL_BITS-1:0]      grid_row,
	input  logic [CELL_BITS-1:0]      grid_col,
	input  logic                      path_end,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [WORLD_W-1:0] world_x,
	output logic signed [WORLD_W-1:0] world_y,
	output logic                      last_waypoint,
	input  dp_cmd_t                   cmd,
	output dp_sts_t                   sts
);

	localparam int unsigned W = CELL_BITS;
	localparam int unsigned D = W + 1;          // signed cell difference
	localparam int unsigned PW1 = 2 * D + 1;    // dot and cross
	localparam int unsigned PW = PW1 + FRAC_BITS;
	localparam int unsigned PRW = RES_W + W;    // resolution times cell index
	localparam int unsigned SW = (PRW >= 33) ? PRW + 2 : 34;

	logic signed [WORLD_W-1:0] origin_x_q, origin_y_q;
	logic [RES_W-1:0]          resolution_q;
	logic [TAN_W-1:0]          tan_q;

	logic [W-1:0] cur_row_q, cur_col_q, held_row_q, held_col_q, older_row_q, older_col_q;
	logic         cur_end_q;

	logic signed [D-1:0]     ux, uy, vx, vy;
	logic signed [2*D-1:0]   p_uxvx_s1, p_uyvy_s1, p_uxvy_s1, p_uyvx_s1;
	logic signed [PW1-1:0]   dot_s2, cross_s2;
	logic                    dneg_s3, dzero_s3, cnz_s3;
	logic [PW1-1:0]          acr_s3;
	logic [PW-1:0]           prod_s3;
	logic [PW-1:0]           lhs;

	logic [W-1:0]   sel_row, sel_col;
	logic [PRW-1:0] px_s1, py_s1;

	logic                      out_valid_q, last_q;
	logic signed [WORLD_W-1:0] wx_q, wy_q;

	// Origin plus a nonnegative product can only overflow upward.
	function automatic logic [WORLD_W-1:0] sat_world(input logic signed [WORLD_W-1:0] o,
		input logic [PRW-1:0] p);
		logic signed [SW-1:0] s;
		s = SW'(o) + $signed(SW'(p));
		if (!s[SW-1] && (|s[SW-2:WORLD_W-1]))
			return {1'b0, {(WORLD_W-1){1'b1}}};
		return s[WORLD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			resolution_q <= RESOLUTION_RST;
			tan_q <= TAN_THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_ORIGIN_X: origin_x_q <= cfg_data[WORLD_W-1:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[WORLD_W-1:0];
				REG_RESOLUTION: resolution_q <= cfg_data[RES_W-1:0];
				REG_TAN_THRESHOLD: tan_q <= cfg_data[TAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			cur_end_q <= 1'b0;
			held_row_q <= '0;
			held_col_q <= '0;
			older_row_q <= '0;
			older_col_q <= '0;
		end else begin
			if (cmd.capture) begin
				cur_row_q <= grid_row;
				cur_col_q <= grid_col;
				cur_end_q <= path_end;
			end
			if (cmd.hold_first || cmd.shift) begin
				held_row_q <= cur_row_q;
				held_col_q <= cur_col_q;
			end
			if (cmd.shift) begin
				older_row_q <= held_row_q;
				older_col_q <= held_col_q;
			end
		end
	end

	assign ux = $signed({1'b0, held_col_q}) - $signed({1'b0, older_col_q});
	assign uy = $signed({1'b0, held_row_q}) - $signed({1'b0, older_row_q});
	assign vx = $signed({1'b0, cur_col_q}) - $signed({1'b0, held_col_q});
	assign vy = $signed({1'b0, cur_row_q}) - $signed({1'b0, held_row_q});

	// Three-stage turn test: products, dot and cross, threshold product.
	always_ff @(posedge clk) begin
		if (cmd.turn_step) begin
			p_uxvx_s1 <= ux * vx;
			p_uyvy_s1 <= uy * vy;
			p_uxvy_s1 <= ux * vy;
			p_uyvx_s1 <= uy * vx;
			dot_s2 <= PW1'(p_uxvx_s1) + PW1'(p_uyvy_s1);
			cross_s2 <= PW1'(p_uxvy_s1) - PW1'(p_uyvx_s1);
			dneg_s3 <= dot_s2[PW1-1];
			dzero_s3 <= (dot_s2 == '0);
			cnz_s3 <= (cross_s2 != '0);
			acr_s3 <= cross_s2[PW1-1] ? $unsigned(-cross_s2) : $unsigned(cross_s2);
			prod_s3 <= PW'(tan_q) * PW'($unsigned(dot_s2));
		end
	end

	assign lhs = {acr_s3, {FRAC_BITS{1'b0}}};
	assign sts.keep = dneg_s3 || (dzero_s3 && cnz_s3)
		|| (!dneg_s3 && !dzero_s3 && (lhs >= prod_s3));
	assign sts.cur_end = cur_end_q;

	assign sel_row = cmd.sel_held ? held_row_q : cur_row_q;
	assign sel_col = cmd.sel_held ? held_col_q : cur_col_q;

	always_ff @(posedge clk) begin
		if (cmd.wmul) begin
			px_s1 <= PRW'(resolution_q) * PRW'(sel_col);
			py_s1 <= PRW'(resolution_q) * PRW'(sel_row);
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			wx_q <= sat_world(origin_x_q, px_s1);
			wy_q <= sat_world(origin_y_q, py_s1);
			last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign world_x = wx_q;
	assign world_y = wy_q;
	assign last_waypoint = last_q;

endmodule

// ===== sv/gptad_ctrl.sv =====
// Controller state machine of the grid path turn angle decimator.
// Depends on gptad_pkg for the command and status structs.
module gptad_ctrl import gptad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_TPROD, S_TSUM, S_TMUL, S_TCMP, S_FIN, S_WMUL, S_WOUT
	} state_t;

	state_t     state_q;
	logic [1:0] ps_q;       // cells of the current path held
	logic       held_sel_q; // the pending emission is of the held cell
	logic       last_q;     // last_waypoint of the pending emission

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.turn_step = (state_q == S_TPROD) || (state_q == S_TSUM) || (state_q == S_TMUL);
		cmd.shift = (state_q == S_FIN) && !sts.cur_end;
		cmd.wmul = (state_q == S_WMUL);
		cmd.sel_held = held_sel_q;
		cmd.load_out = (state_q == S_WOUT) && sts.out_free;
		cmd.hold_first = cmd.load_out && !held_sel_q && !last_q;
		cmd.last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ps_q <= 2'd0;
			held_sel_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DEC;
				end
				S_DEC: begin
					if (ps_q == 2'd0) begin
						held_sel_q <= 1'b0;
						last_q <= sts.cur_end;
						state_q <= S_WMUL;
					end else if (ps_q == 2'd2) begin
						state_q <= S_TPROD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_TPROD: state_q <= S_TSUM;
				S_TSUM: state_q <= S_TMUL;
				S_TMUL: state_q <= S_TCMP;
				S_TCMP: begin
					if (sts.keep) begin
						held_sel_q <= 1'b1;
						last_q <= 1'b0;
						state_q <= S_WMUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (sts.cur_end) begin
						held_sel_q <= 1'b0;
						last_q <= 1'b1;
						state_q <= S_WMUL;
					end else begin
						ps_q <= 2'd2;
						state_q <= S_IDLE;
					end
				end
				S_WMUL: state_q <= S_WOUT;
				S_WOUT: begin
					if (sts.out_free) begin
						if (held_sel_q) begin
							state_q <= S_FIN;
						end else begin
							ps_q <= last_q ? 2'd0 : 2'd1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_capture_decides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_DEC)
		else $error("captured word not followed by the decision step");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register loaded while still occupied");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ps_q != 2'd3)
		else $error("held cell count out of range");
	a_emit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WOUT && sts.out_free) |=> (state_q == S_IDLE || state_q == S_FIN))
		else $error("emission did not return to the path sequence");
	a_shift_needs_cells: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (ps_q != 2'd0))
		else $error("history shifted with no held cell");
`endif

endmodule

// ===== sv/grid_path_turn_angle_decimator.sv =====
// Top level of the grid path turn angle decimator: controller plus datapath.
// Depends on gptad_pkg, gptad_if, gptad_ctrl and gptad_dp.
//
//   channel    role   words carried
//   path       sink   grid_row, grid_col, path_end
//   waypoint   source world_x, world_y, last_waypoint
//   cfg        sink   addr, data (register writes, always ready)
//
// A cell word that only enters the history passes the decision and finish steps;
// the first cell of a path is mapped and sent. A middle cell first runs through
// the three-stage turn test, which keeps or drops it, and a final cell is sent.
// Sending is the world mapping: a multiply step, then the output register load.
// Reset clears the controller, the cell history and restores the register defaults.
// A stalled waypoint channel holds the controller in its output step; the next
// cell word is still taken while the last waypoint waits in the output register.
module grid_path_turn_angle_decimator import gptad_pkg::*; #(
	parameter int unsigned CELL_BITS = CELL_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	gptad_cell_if.sink  path,
	gptad_wpt_if.source waypoint,
	gptad_cfg_if.sink   cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Register writes are always taken; software must write only while idle, which the block does not enforce.
	assign cfg.ready = 1'b1;

	// The controller sequences one cell word at a time.
	gptad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (path.valid),
		.in_ready (path.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the registers, the history and the output word.
	gptad_dp #(
		.CELL_BITS (CELL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg.valid),
		.cfg_addr      (cfg.addr),
		.cfg_data      (cfg.data),
		.grid_row      (path.grid_row),
		.grid_col      (path.grid_col),
		.path_end      (path.path_end),
		.out_valid     (waypoint.valid),
		.out_ready     (waypoint.ready),
		.world_x       (waypoint.world_x),
		.world_y       (waypoint.world_y),
		.last_waypoint (waypoint.last_waypoint),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== test/tb_grid_path_turn_angle_decimator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of grid_path_turn_angle_decimator: a directed table of paths, then
// random paths under several register settings, checked against an in-bench decimator model.
// Depends on gptad_pkg, the gptad_if interfaces and the RTL of the block.
module tb_grid_path_turn_angle_decimator;
	import gptad_pkg::*;

	localparam int unsigned CELL_BITS = CELL_BITS_DEF;
	localparam int CELL_MAX = (1 << CELL_BITS) - 1;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 220;
	// Covers the slowest cell word inside the block, a kept middle cell plus the final cell, with margin.
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam longint WORLD_MAX = (longint'(1) << (WORLD_W - 1)) - 1;
	localparam longint WORLD_MIN = -(longint'(1) << (WORLD_W - 1));
	// Register indexes that the block must ignore.
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = REG_TAN_THRESHOLD + 1'b1;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = '1;

	typedef struct packed {
		logic [CELL_BITS-1:0] row;
		logic [CELL_BITS-1:0] col;
	} cell_t;

	typedef struct {
		logic signed [WORLD_W-1:0] x;
		logic signed [WORLD_W-1:0] y;
		logic                      last;
	} waypoint_t;

	// One row of the directed table. Where typed is set, the expected waypoint is written
	// out by hand and replaces the one the model would give; such rows yield one waypoint.
	typedef struct {
		int unsigned row;
		int unsigned col;
		bit          fin;
		bit          typed;
		int          ex;
		int          ey;
		bit          elast;
	} dir_row_t;

	// With the reset resolution of 3277, cell 4095 maps to 3277 * 4095 = 13419315.
	dir_row_t dir_tab [25] = '{
		// single-cell paths right after reset, corners of the grid
		'{0, 0, 1, 1, 0, 0, 1},
		'{4095, 4095, 1, 1, 13419315, 13419315, 1},
		'{4095, 0, 1, 1, 0, 13419315, 1},
		// straight run: no middle cell survives
		'{10, 10, 0, 0, 0, 0, 0}, '{10, 11, 0, 0, 0, 0, 0},
		'{10, 12, 0, 0, 0, 0, 0}, '{10, 13, 1, 0, 0, 0, 0},
		// right angle: zero dot product with a nonzero cross product
		'{5, 5, 0, 0, 0, 0, 0}, '{5, 9, 0, 0, 0, 0, 0}, '{9, 9, 1, 0, 0, 0, 0},
		// full reversal across the grid: negative dot product
		'{0, 0, 0, 0, 0, 0, 0}, '{0, 4095, 0, 0, 0, 0, 0}, '{0, 0, 1, 0, 0, 0, 0},
		// repeated cells: zero-length segments are dropped
		'{3, 3, 0, 0, 0, 0, 0}, '{3, 3, 0, 0, 0, 0, 0},
		'{3, 3, 0, 0, 0, 0, 0}, '{3, 4, 1, 0, 0, 0, 0},
		// shallow bend well below the default threshold
		'{0, 0, 0, 0, 0, 0, 0}, '{0, 100, 0, 0, 0, 0, 0}, '{1, 200, 1, 0, 0, 0, 0},
		// two-cell path: first and last only
		'{100, 200, 0, 0, 0, 0, 0}, '{300, 400, 1, 0, 0, 0, 0},
		// jumps between opposite corners
		'{4095, 0, 0, 0, 0, 0, 0}, '{0, 4095, 0, 0, 0, 0, 0}, '{4095, 4095, 1, 0, 0, 0, 0}
	};

	bit   clk = 1'b0;
	logic arst_n;

	gptad_cell_if #(.CELL_BITS(CELL_BITS)) path_if ();
	gptad_wpt_if                           wpt_if ();
	gptad_cfg_if                           cfg_if ();

	grid_path_turn_angle_decimator #(.CELL_BITS(CELL_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.path     (path_if),
		.waypoint (wpt_if),
		.cfg      (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model of the decimator: its own register copies and cell history.
	logic signed [WORLD_W-1:0] org_x_q, org_y_q;
	logic [RES_W-1:0]          res_q;
	logic [TAN_W-1:0]          tan_q;
	logic [1:0]                seen_q;
	cell_t                     older_q, held_q;

	// Waypoints still owed by the block, oldest first.
	waypoint_t waypoints_due [$];

	// The typed expectation travels with the cell word on the same clock edges.
	logic      typed_pend;
	waypoint_t typed_wp_pend;

	int errors, cells_taken, waypoints_seen, kept_turns, sat_hits, paths_sent, sent;
	int burst_left, gap_max;
	bit rx_full;

	logic [15:0] stall_pat;
	logic [3:0]  pat_pos = '0;

	// World coordinate of one grid index: origin plus resolution times index, saturated.
	function automatic logic signed [WORLD_W-1:0] to_world(
		input logic signed [WORLD_W-1:0] origin,
		input logic [CELL_BITS-1:0]      idx
	);
		longint v;
		v = longint'(origin) + longint'(res_q) * longint'(idx);
		if (v > WORLD_MAX) begin
			v = WORLD_MAX;
			sat_hits++;
		end else if (v < WORLD_MIN) begin
			v = WORLD_MIN;
			sat_hits++;
		end
		return WORLD_W'(v);
	endfunction

	function automatic void queue_waypoint(input cell_t c, input logic fin);
		waypoint_t w;
		w.x = to_world(org_x_q, c.col);
		w.y = to_world(org_y_q, c.row);
		w.last = fin;
		waypoints_due.push_back(w);
	endfunction

	// Decides on the held cell once the cell after it is known, and always passes on
	// the first and the final cell of a path.
	function automatic void decimate_cell(input cell_t c, input logic fin);
		longint ux, uy, vx, vy, dot_p, crs;
		bit     keep;
		if (seen_q == 2'd0) begin
			queue_waypoint(c, fin);
			if (!fin) begin
				held_q = c;
				seen_q = 2'd1;
			end
		end else begin
			if (seen_q >= 2'd2) begin
				ux = longint'(held_q.col) - longint'(older_q.col);
				uy = longint'(held_q.row) - longint'(older_q.row);
				vx = longint'(c.col) - longint'(held_q.col);
				vy = longint'(c.row) - longint'(held_q.row);
				dot_p = ux * vx + uy * vy;
				crs = ux * vy - uy * vx;
				if (crs < 0)
					crs = -crs;
				// The angle test without atan2: a sharp bend always stays, a right
				// angle stays unless a segment has zero length, and an obtuse bend
				// stays when |cross| / dot reaches the threshold tangent.
				keep = (dot_p < 0) || (dot_p == 0 && crs != 0) ||
					(dot_p > 0 && (crs << FRAC_BITS) >= longint'(tan_q) * dot_p);
				if (keep) begin
					queue_waypoint(held_q, 1'b0);
					kept_turns++;
				end
			end
			if (fin) begin
				queue_waypoint(c, 1'b1);
				seen_q = 2'd0;
			end else begin
				older_q = held_q;
				held_q = c;
				seen_q = 2'd2;
			end
		end
	endfunction

	task automatic check_field(
		input string                     name,
		input logic signed [WORLD_W-1:0] want,
		input logic signed [WORLD_W-1:0] got
	);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// All three channels are sampled at the rising edge, before any of this edge's
	// updates, so a word counts exactly when valid and ready were both high.
	always @(posedge clk) begin : scoreboard
		waypoint_t want;
		cell_t     got_cell;
		if (arst_n) begin
			if (wpt_if.valid && wpt_if.ready) begin
				if (waypoints_due.size() == 0) begin
					errors++;
					$error("waypoint (%0d, %0d) arrived with none expected",
						wpt_if.world_x, wpt_if.world_y);
				end else begin
					want = waypoints_due.pop_front();
					check_field("world_x", want.x, wpt_if.world_x);
					check_field("world_y", want.y, wpt_if.world_y);
					check_field("last_waypoint", WORLD_W'(want.last),
						WORLD_W'(wpt_if.last_waypoint));
					waypoints_seen++;
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.addr)
					REG_ORIGIN_X: org_x_q = cfg_if.data;
					REG_ORIGIN_Y: org_y_q = cfg_if.data;
					REG_RESOLUTION: res_q = cfg_if.data[RES_W-1:0];
					REG_TAN_THRESHOLD: tan_q = cfg_if.data[TAN_W-1:0];
					default: ;
				endcase
			end
			if (path_if.valid && path_if.ready) begin
				got_cell.row = path_if.grid_row;
				got_cell.col = path_if.grid_col;
				decimate_cell(got_cell, path_if.path_end);
				if (typed_pend)
					waypoints_due[$] = typed_wp_pend;
				cells_taken++;
			end
		end
	end

	// Waypoint receiver: each time the pattern position wraps it picks a new ready pattern,
	// from no stalls at all to a single ready bit in the sixteen-bit pattern.
	always @(posedge clk) begin : rx_pace
		if (pat_pos == 4'd0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = 16'($urandom) | 16'h0001;
				2: stall_pat = 16'h5555;
				default: stall_pat = 16'h0001;
			endcase
		end
		wpt_if.ready <= rx_full | stall_pat[pat_pos];
		pat_pos = pat_pos + 4'd1;
	end

	// Ends the run when no word has moved on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((path_if.valid && path_if.ready) || (wpt_if.valid && wpt_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no word moved for %0d cycles, %0d waypoints still owed",
			QUIET_LIMIT, waypoints_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Sender pacing: bursts of random length with random gaps between them.
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				path_if.valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Offers one cell word and returns at the edge where it is taken. Valid stays
	// high so that the next word can follow without a gap.
	task automatic send_cell(input cell_t c, input bit fin, input bit typed,
		input waypoint_t tw);
		path_if.valid <= 1'b1;
		path_if.grid_row <= c.row;
		path_if.grid_col <= c.col;
		path_if.path_end <= fin;
		typed_pend <= typed;
		typed_wp_pend <= tw;
		do @(posedge clk); while (!path_if.ready);
		sent++;
		if (fin)
			paths_sent++;
	endtask

	// Holds the sender until every owed waypoint has come, then lets the block finish
	// a cell that yields no waypoint.
	task automatic wait_drained();
		path_if.valid <= 1'b0;
		do @(posedge clk); while (waypoints_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	initial begin : stimulus
		cell_t                 cur;
		waypoint_t             typed_wp, no_wp;
		logic [CFG_ADDR_W-1:0] reg_idx [6];
		logic [CFG_DATA_W-1:0] reg_val [6];
		int                    phase_start, len, style, r, c, dr, dc;
		bit                    paused;

		arst_n = 1'b0;
		path_if.valid = 1'b0;
		path_if.grid_row = '0;
		path_if.grid_col = '0;
		path_if.path_end = 1'b0;
		wpt_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.addr = '0;
		cfg_if.data = '0;
		typed_pend = 1'b0;
		no_wp = '{default: '0};
		typed_wp_pend = no_wp;
		org_x_q = '0;
		org_y_q = '0;
		res_q = RESOLUTION_RST;
		tan_q = TAN_THRESHOLD_RST;
		seen_q = '0;
		older_q = '0;
		held_q = '0;
		reg_idx = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_RESOLUTION, REG_TAN_THRESHOLD,
			REG_UNUSED_LO, REG_UNUSED_HI};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < N_PHASES; p++) begin
			// Registers change only while the block is idle: outside phase 0 the block
			// is drained first, then every register gets a value, plus two writes to
			// indexes that must have no effect.
			if (p > 0) begin
				wait_drained();
				case (p)
					1: begin
						reg_val[0] = 32'h7FFF_FFFF;
						reg_val[1] = 32'h8000_0000;
						reg_val[2] = 32'h000F_FFFF;
						reg_val[3] = '0;
					end
					2: begin
						reg_val[0] = 32'h8000_0000;
						reg_val[1] = 32'h7FFF_FFFF;
						reg_val[2] = '0;
						reg_val[3] = 32'h0000_FFFF;
					end
					3: begin
						// A threshold of one half makes ties of |cross| * 2 == dot common.
						reg_val[0] = $urandom;
						reg_val[1] = $urandom;
						reg_val[2] = $urandom;
						reg_val[3] = 32'h0000_8000;
					end
					4: begin
						reg_val[0] = $urandom;
						reg_val[1] = $urandom;
						reg_val[2] = $urandom;
						reg_val[3] = $urandom;
					end
					default: begin
						reg_val[0] = '0;
						reg_val[1] = '0;
						reg_val[2] = $urandom_range(1, 32'h0001_0000);
						reg_val[3] = $urandom_range(0, 255);
					end
				endcase
				reg_val[4] = $urandom;
				reg_val[5] = $urandom;
				foreach (reg_idx[i]) begin
					cfg_if.valid <= 1'b1;
					cfg_if.addr <= reg_idx[i];
					cfg_if.data <= reg_val[i];
					do @(posedge clk); while (!cfg_if.ready);
				end
				cfg_if.valid <= 1'b0;
			end

			// Phase 1 runs with neither side idling; the rest idle on both sides.
			gap_max = (p == 1) ? 0 : 6;
			rx_full <= (p == 1);

			if (p == 0) begin
				foreach (dir_tab[i]) begin
					pace();
					cur.row = CELL_BITS'(dir_tab[i].row);
					cur.col = CELL_BITS'(dir_tab[i].col);
					typed_wp.x = dir_tab[i].ex;
					typed_wp.y = dir_tab[i].ey;
					typed_wp.last = dir_tab[i].elast;
					send_cell(cur, dir_tab[i].fin, dir_tab[i].typed, typed_wp);
				end
			end

			// Random paths. Most are walks with a slowly drifting heading, which puts
			// many bends near the threshold; some repeat cells, some jump anywhere.
			phase_start = sent;
			paused = 1'b0;
			while (sent - phase_start < ITEMS_PER_PHASE) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
				style = $urandom_range(0, 9);
				case ($urandom_range(0, 3))
					0: begin
						r = $urandom_range(0, CELL_MAX);
						c = $urandom_range(0, CELL_MAX);
					end
					1: begin
						r = $urandom_range(0, 1) * CELL_MAX;
						c = $urandom_range(0, 1) * CELL_MAX;
					end
					default: begin
						r = $urandom_range(64, CELL_MAX - 64);
						c = $urandom_range(64, CELL_MAX - 64);
					end
				endcase
				dr = int'($urandom_range(0, 6)) - 3;
				dc = int'($urandom_range(0, 6)) - 3;
				for (int k = 0; k < len; k++) begin
					if (k > 0) begin
						if (style == 9 || $urandom_range(0, 19) == 0) begin
							r = $urandom_range(0, CELL_MAX);
							c = $urandom_range(0, CELL_MAX);
						end else if (!(style == 8 && $urandom_range(0, 1) == 1)) begin
							if ($urandom_range(0, 3) == 0) begin
								if ($urandom_range(0, 1) == 1)
									dr += int'($urandom_range(0, 2)) - 1;
								else
									dc += int'($urandom_range(0, 2)) - 1;
							end
							if (dr > 4) dr = 4;
							if (dr < -4) dr = -4;
							if (dc > 4) dc = 4;
							if (dc < -4) dc = -4;
							r += dr;
							c += dc;
							if (r < 0) r = 0;
							if (r > CELL_MAX) r = CELL_MAX;
							if (c < 0) c = 0;
							if (c > CELL_MAX) c = CELL_MAX;
						end
					end
					pace();
					cur.row = CELL_BITS'(r);
					cur.col = CELL_BITS'(c);
					send_cell(cur, k == len - 1, 1'b0, no_wp);
				end
				// Once per phase the sender waits for the block to empty out.
				if (!paused && sent - phase_start >= ITEMS_PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		$display("Summary: %0d cells in %0d paths over %0d register settings, %0d waypoints checked",
			cells_taken, paths_sent, N_PHASES, waypoints_seen);
		$display("Summary: %0d bends kept, %0d coordinates saturated, %0d mismatches",
			kept_turns, sat_hits, errors);
		if (errors == 0 && waypoints_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
sv/gptad_pkg.sv
sv/gptad_if.sv
sv/gptad_dp.sv
sv/gptad_ctrl.sv
sv/grid_path_turn_angle_decimator.sv
test/tb_grid_path_turn_angle_decimator.sv
